// ===== rtl/pff_pkg.sv =====
package pff_pkg;

    localparam int BUFFER_DEPTH = 128;

    localparam int FRAME_LEN = 32;
    localparam int SUM_LEN   = 30;
    localparam int SUM_W     = 13;
    localparam int AGE_W     = 12;

    localparam logic [7:0] HEAD_A = 8'h42;
    localparam logic [7:0] HEAD_B = 8'h4D;

    localparam logic [AGE_W-1:0] AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] AGE_LIMIT = AGE_W'(BUFFER_DEPTH - 33);

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    typedef struct packed {
        logic        found;
        logic [15:0] pm25;
    } t_frame_status;

endpackage

// ===== rtl/pff_window.sv =====
module pff_window
    import pff_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_en,
    input  logic [7:0]    i_byte,
    output t_frame_status o_status
);

    logic [7:0]       r_win [FRAME_LEN];
    logic [SUM_W-1:0] r_sum;
    logic [15:0]      r_reading;
    logic [AGE_W-1:0] r_age;
    logic             r_seen;

    logic [SUM_W-1:0] n_sum;
    logic             n_hit;
    logic [AGE_W-1:0] n_age;

    always_comb begin
        n_sum = r_sum + SUM_W'(r_win[SUM_LEN]) - SUM_W'(r_win[0]);
        n_hit = (r_win[1] == HEAD_A) && (r_win[2] == HEAD_B)
              && ({r_win[FRAME_LEN-1], i_byte} == 16'(n_sum));
        if (n_hit) begin
            n_age = '0;
        end else if (r_age != AGE_MAX) begin
            n_age = r_age + AGE_W'(1);
        end else begin
            n_age = r_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_sum     <= '0;
            r_reading <= '0;
            r_age     <= AGE_MAX;
            r_seen    <= 1'b0;
        end else if (i_byte_en) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[FRAME_LEN-1] <= i_byte;
            r_sum <= n_sum;
            r_age <= n_age;
            if (n_hit) begin
                r_reading <= {r_win[7], r_win[8]};
                r_seen    <= 1'b1;
            end
        end
    end

    assign o_status.found = r_seen && (r_age <= AGE_LIMIT);
    assign o_status.pm25  = r_reading;

endmodule

// ===== rtl/particulate_frame_finder.sv =====
// Particulate frame finder: takes one transfer per clock on the slave side, either a received
// sensor byte (tuser = 0) or a poll (tuser = 1). Bytes pass through a 32-byte window that is
// checked for a valid frame at every byte offset; a valid frame latches its PM2.5 word. Each
// poll yields one result: the poll is held in the input register until the output register is
// free, then its result is registered in the output register and offered on the master side.
// The result carries the latched reading and a found flag that is set while the latest valid
// frame ended at most BUFFER_DEPTH-33 bytes ago. Bytes yield no result. Throughput is one item
// per cycle, set by the single input register feeding the window logic and the output
// register; the slave side stalls only while a poll waits behind an untaken result. After
// reset the window reads as zeros and no frame is held.
module particulate_frame_finder
    import pff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pm25_level
    output logic        m_axis_tuser    // [0] found
);

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic        r_out_found;
    logic [15:0] r_out_pm25;

    logic          w_out_free;
    logic          w_advance;
    logic          w_byte_en;
    logic          w_poll_fire;
    t_frame_status w_status;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && ((r_in_cmd == CMD_BYTE) || w_out_free);
    assign w_byte_en     = r_in_valid && (r_in_cmd == CMD_BYTE);
    assign w_poll_fire   = r_in_valid && (r_in_cmd == CMD_POLL) && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    pff_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (w_byte_en),
        .i_byte    (r_in_byte),
        .o_status  (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_poll_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_poll_fire) begin
            r_out_found <= w_status.found;
            r_out_pm25  <= w_status.pm25;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pm25;
    assign m_axis_tuser  = r_out_found;

endmodule

// ===== rtl/pff_checker.sv =====
module pff_checker
    import pff_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    a_result_from_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_POLL), 2))
        else $error("result without a poll");

endmodule

bind particulate_frame_finder pff_checker u_checker (.*);

// ===== test/pff_tracker_pkg.sv =====
package pff_tracker_pkg;

    import pff_pkg::*;

    class pm_frame_tracker;
        logic [7:0]       window [FRAME_LEN];
        logic [SUM_W-1:0] head_sum;
        logic [15:0]      reading;
        logic [AGE_W-1:0] age;
        bit               seen;
        t_frame_status    replies [$];
        int               errors;
        int               byte_count;
        int               poll_count;
        int               frame_count;
        int               fresh_count;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            head_sum    = '0;
            reading     = '0;
            age         = AGE_MAX;
            seen        = 1'b0;
            errors      = 0;
            byte_count  = 0;
            poll_count  = 0;
            frame_count = 0;
            fresh_count = 0;
        endfunction

        function void take_transfer(logic cmd, logic [7:0] value);
            t_frame_status reply;
            if (cmd == CMD_POLL) begin
                reply.found = seen && (age <= AGE_LIMIT);
                reply.pm25  = reading;
                replies.push_back(reply);
                poll_count++;
                if (reply.found) fresh_count++;
            end else begin
                byte_count++;
                if (age != AGE_MAX) age++;
                // byte at index SUM_LEN moves into the summed span, index 0 leaves it
                head_sum = head_sum + SUM_W'(window[SUM_LEN]) - SUM_W'(window[0]);
                for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i + 1];
                window[FRAME_LEN - 1] = value;
                if (window[0] == HEAD_A && window[1] == HEAD_B &&
                        {window[FRAME_LEN - 2], window[FRAME_LEN - 1]} == 16'(head_sum)) begin
                    reading = {window[6], window[7]};
                    age     = '0;
                    seen    = 1'b1;
                    frame_count++;
                end
            end
        endfunction

        function void match_reply(logic found, logic [15:0] pm25, time stamp);
            t_frame_status want;
            if (replies.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: result with none pending, actual found=%0b pm25=%04h",
                             stamp, found, pm25);
            end else begin
                want = replies.pop_front();
                if (want.found !== found) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: found mismatch, expected %0b actual %0b",
                                 stamp, want.found, found);
                end
                if (want.pm25 !== pm25) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: pm25 mismatch, expected %04h actual %04h",
                                 stamp, want.pm25, pm25);
                end
            end
        endfunction
    endclass

endpackage

// ===== test/particulate_frame_finder_tb.sv =====
module particulate_frame_finder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pff_pkg::*;
    import pff_tracker_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_value
    logic        s_axis_tuser = 1'b0;    // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;           // [15:0] pm25_level
    logic        m_axis_tuser;           // [0] found

    pm_frame_tracker sb = new();

    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    particulate_frame_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic push_item(input logic cmd, input logic [7:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_transfer(cmd, value);
        @(negedge i_clk);
    endtask

    task automatic send_noise(input int count, input bit zeros, input int poll_odds);
        logic [7:0] value;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       value = HEAD_A;
                1:       value = HEAD_B;
                default: value = 8'($urandom);
            endcase
            push_item(CMD_BYTE, zeros ? 8'h00 : value);
            if (poll_odds > 0 && $urandom_range(1, poll_odds) == 1)
                push_item(CMD_POLL, 8'($urandom));
        end
    endtask

    task automatic send_frame(input logic [15:0] pm25, input bit broken, input bit filled,
                              input int poll_odds);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] total;
        int          spot;
        frame[0] = HEAD_A;
        frame[1] = HEAD_B;
        for (int i = 2; i < SUM_LEN; i++) frame[i] = filled ? 8'hFF : 8'($urandom);
        frame[6] = pm25[15:8];
        frame[7] = pm25[7:0];
        total = '0;
        for (int i = 0; i < SUM_LEN; i++) total = total + 16'(frame[i]);
        frame[SUM_LEN]     = total[15:8];
        frame[SUM_LEN + 1] = total[7:0];
        if (broken) begin
            spot = $urandom_range(0, FRAME_LEN - 1);
            frame[spot] = frame[spot] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            push_item(CMD_BYTE, frame[i]);
            if (poll_odds > 0 && $urandom_range(1, poll_odds) == 1)
                push_item(CMD_POLL, 8'($urandom));
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.match_reply(m_axis_tuser, m_axis_tdata, $time);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int  base;
        bit  pressed;
        bit  paused;
        int  done;
        pressed = 1'b0;
        paused  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        push_item(CMD_POLL, 8'hFF);
        send_noise(3, 1'b1, 0);
        push_item(CMD_POLL, 8'h00);
        send_frame(16'hFFFF, 1'b0, 1'b0, 0);
        push_item(CMD_POLL, 8'hA5);
        push_item(CMD_POLL, 8'h5A);
        send_noise(int'(AGE_LIMIT), 1'b1, 0);
        push_item(CMD_POLL, 8'h00);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_POLL, 8'h00);
        send_frame(16'h0000, 1'b0, 1'b0, 0);
        push_item(CMD_POLL, 8'h00);
        send_frame(16'h1234, 1'b1, 1'b0, 0);
        push_item(CMD_POLL, 8'h00);
        send_frame(16'hFFFF, 1'b0, 1'b1, 0);
        push_item(CMD_POLL, 8'hFF);

        idle_on = 1'b1;
        base = sb.byte_count + sb.poll_count;
        done = 0;
        while (done < 1300) begin
            if (done > 400 && !pressed) begin
                pressed  = 1'b1;
                hold_req = 1'b1;
                repeat (12) push_item(CMD_POLL, 8'($urandom));
                send_noise(8, 1'b0, 2);
            end
            if (done > 800 && !paused) begin
                paused = 1'b1;
                s_axis_tvalid = 1'b0;
                while (sb.replies.size() != 0) @(negedge i_clk);
            end
            if (done > 1000) idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_noise($urandom_range(0, 40), 1'b0, 8);
                    send_frame(16'($urandom), 1'b0, 1'b0, 8);
                end
                6: begin
                    send_noise($urandom_range(0, 10), 1'b0, 8);
                    send_frame(16'($urandom), 1'b1, 1'b0, 8);
                end
                7: begin
                    send_noise($urandom_range(int'(AGE_LIMIT) - 4, int'(AGE_LIMIT) + 4),
                               1'b1, 0);
                    push_item(CMD_POLL, 8'($urandom));
                end
                8:       repeat ($urandom_range(1, 6)) push_item(CMD_POLL, 8'($urandom));
                default: send_noise($urandom_range(1, 60), 1'b0, 4);
            endcase
            done = sb.byte_count + sb.poll_count - base;
        end

        send_frame(16'($urandom), 1'b0, 1'b0, 0);
        send_noise(int'(AGE_LIMIT) + 100, 1'b1, 0);
        push_item(CMD_POLL, 8'($urandom));
        send_frame(16'($urandom), 1'b0, 1'b0, 0);
        push_item(CMD_POLL, 8'($urandom));

        s_axis_tvalid = 1'b0;
        while (sb.replies.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Run covered %0d byte transfers and %0d polls, %0d frames latched.",
                 sb.byte_count, sb.poll_count, sb.frame_count);
        $display("%0d polls saw a recent frame, %0d saw none or a stale one.",
                 sb.fresh_count, sb.poll_count - sb.fresh_count);
        if (sb.errors == 0 && sb.replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
